[design/uvsv_pkg.sv]
package uvsv_pkg;

   // Field and datapath widths.
   localparam int SEG_W = 11;
   localparam int TEX_W = 17;
   localparam int COORD_W = 16;
   localparam int PHASE_W = 32;
   localparam int TRIG_W = 32;

   // Long division: one dividend bit per cell, wide enough for index * 2^32.
   localparam int DIV_W = 43;
   localparam int DIV_LANES = 4;
   localparam int THETA_SHIFT = 31;
   localparam int PHI_SHIFT = 32;
   localparam int TEX_SHIFT = 16;

   // Rotation CORDIC on Q30 values with guard bits.
   localparam int CORDIC_W = 34;
   localparam int CORDIC_STEPS = 28;
   localparam int STEP_W = 5;
   localparam int CORDIC_LANES = 2;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

   typedef enum logic [0:0] {
      CSR_LAT_SEGMENTS = 1'b0,
      CSR_LON_SEGMENTS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   typedef struct packed {
      logic [SEG_W-1:0] rem;
      logic [DIV_W-1:0] nq;
   } div_lane_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
      logic               index_clamped;
   } rsp_word_type;

   // Arctangent of 2^-step in units of 2^-32 turn.
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] step);
      logic signed [CORDIC_W-1:0] a;
      case (step)
         5'd0:    a = 34'sh020000000;
         5'd1:    a = 34'sh012E4051E;
         5'd2:    a = 34'sh009FB385B;
         5'd3:    a = 34'sh0051111D4;
         5'd4:    a = 34'sh0028B0D43;
         5'd5:    a = 34'sh00145D7E1;
         5'd6:    a = 34'sh000A2F61E;
         5'd7:    a = 34'sh000517C55;
         5'd8:    a = 34'sh00028BE53;
         5'd9:    a = 34'sh000145F2F;
         5'd10:   a = 34'sh0000A2F98;
         5'd11:   a = 34'sh0000517CC;
         5'd12:   a = 34'sh000028BE6;
         5'd13:   a = 34'sh0000145F3;
         5'd14:   a = 34'sh00000A2FA;
         5'd15:   a = 34'sh00000517D;
         5'd16:   a = 34'sh0000028BE;
         5'd17:   a = 34'sh00000145F;
         5'd18:   a = 34'sh000000A30;
         5'd19:   a = 34'sh000000518;
         5'd20:   a = 34'sh00000028C;
         5'd21:   a = 34'sh000000146;
         5'd22:   a = 34'sh0000000A3;
         5'd23:   a = 34'sh000000051;
         5'd24:   a = 34'sh000000029;
         5'd25:   a = 34'sh000000014;
         5'd26:   a = 34'sh00000000A;
         5'd27:   a = 34'sh000000005;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[design/uv_sphere_vertex_generator.sv]
// A request word reaches rsp_valid through a chain of 74 registers (43 division cells,
// 28 CORDIC cells, fold, product and output stages).
// Throughput: one word per cycle; two finished words can wait at the output, and
// requests are refused only while the skid slot is occupied.
// Reset clears every valid bit and loads 16 latitude and 32 longitude segments.
module uv_sphere_vertex_generator #(
   parameter int MAX_SEGMENTS = 1024,
   parameter int COORD_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [uvsv_pkg::SEG_W-1:0]    req_lat_index,
   input  logic [uvsv_pkg::SEG_W-1:0]    req_lon_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [uvsv_pkg::COORD_W-1:0] rsp_pos_x,
   output logic signed [uvsv_pkg::COORD_W-1:0] rsp_pos_y,
   output logic signed [uvsv_pkg::COORD_W-1:0] rsp_pos_z,
   output logic [uvsv_pkg::TEX_W-1:0]    rsp_tex_u,
   output logic [uvsv_pkg::TEX_W-1:0]    rsp_tex_v,
   output logic                          rsp_index_clamped,
   input  logic                          csr_write_enable,
   input  uvsv_pkg::csr_index_type       csr_index,
   input  logic [uvsv_pkg::SEG_W-1:0]    csr_wdata
);
   import uvsv_pkg::*;

   localparam int SHIFT_XZ = 60 - COORD_FRAC_BITS;
   localparam int SHIFT_Y = 30 - COORD_FRAC_BITS;
   localparam logic signed [64:0] XZ_BIAS = 65'sd1 <<< (SHIFT_XZ - 1);
   localparam logic signed [64:0] Y_BIAS = (SHIFT_Y == 0) ? 65'sd0 : (65'sd1 <<< (SHIFT_Y - 1));
   localparam logic signed [64:0] SAT_HI = (COORD_FRAC_BITS >= 15) ? 65'sd32767 :
                                           ((65'sd1 <<< COORD_FRAC_BITS) - 65'sd1);
   localparam logic signed [64:0] SAT_LO = (COORD_FRAC_BITS >= 15) ? -65'sd32768 :
                                           -(65'sd1 <<< COORD_FRAC_BITS);

   function automatic logic [SEG_W-1:0] eff_seg(input logic [SEG_W-1:0] r);
      logic [SEG_W-1:0] e;
      if (r == '0) begin
         e = SEG_W'(1);
      end else if (32'(r) > MAX_SEGMENTS) begin
         e = SEG_W'(MAX_SEGMENTS);
      end else begin
         e = r;
      end
      return e;
   endfunction

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [64:0] v);
      logic [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] quad_cos(input quad_type q,
                                                         input cordic_vec_type v);
      logic signed [CORDIC_W-1:0] c;
      case (q)
         QUAD_FIRST:  c = v.x;
         QUAD_SECOND: c = -v.y;
         QUAD_THIRD:  c = -v.x;
         default:     c = v.y;
      endcase
      return TRIG_W'(c);
   endfunction

   function automatic logic signed [TRIG_W-1:0] quad_sin(input quad_type q,
                                                         input cordic_vec_type v);
      logic signed [CORDIC_W-1:0] s;
      case (q)
         QUAD_FIRST:  s = v.y;
         QUAD_SECOND: s = v.x;
         QUAD_THIRD:  s = -v.y;
         default:     s = -v.x;
      endcase
      return TRIG_W'(s);
   endfunction

   logic [SEG_W-1:0] lat_seg_ff;
   logic [SEG_W-1:0] lon_seg_ff;
   logic [SEG_W-1:0] lat_eff;
   logic [SEG_W-1:0] lon_eff;
   logic [SEG_W-1:0] lat_idx;
   logic [SEG_W-1:0] lon_idx;
   logic             clamp_now;
   logic             advance;

   div_lane_type     div_src [DIV_LANES];
   div_lane_type     div_tap [DIV_LANES][DIV_W];
   logic [SEG_W-1:0] lane_seg [DIV_LANES];
   logic [DIV_W-1:0] div_v_ff;
   logic [DIV_W-1:0] div_clamp_ff;

   logic [PHASE_W-1:0] th_phase;
   logic [PHASE_W-1:0] ph_phase;
   cordic_vec_type   cor_src [CORDIC_LANES];
   cordic_vec_type   cor_tap [CORDIC_LANES][CORDIC_STEPS];
   logic [CORDIC_STEPS-1:0] cor_v_ff;
   logic [CORDIC_STEPS-1:0] cor_clamp_ff;
   logic [TEX_W-1:0] cor_tu_ff [CORDIC_STEPS];
   logic [TEX_W-1:0] cor_tv_ff [CORDIC_STEPS];
   quad_type         cor_qt_ff [CORDIC_STEPS];
   quad_type         cor_qp_ff [CORDIC_STEPS];

   logic                     map_v_ff;
   logic signed [TRIG_W-1:0] ct_ff;
   logic signed [TRIG_W-1:0] st_ff;
   logic signed [TRIG_W-1:0] cp_ff;
   logic signed [TRIG_W-1:0] sp_ff;
   logic [TEX_W-1:0]         map_tu_ff;
   logic [TEX_W-1:0]         map_tv_ff;
   logic                     map_clamp_ff;

   logic                           mul_v_ff;
   logic signed [2*TRIG_W-1:0]     px_ff;
   logic signed [2*TRIG_W-1:0]     pz_ff;
   logic signed [TRIG_W-1:0]       py_ff;
   logic [TEX_W-1:0]               mul_tu_ff;
   logic [TEX_W-1:0]               mul_tv_ff;
   logic                           mul_clamp_ff;

   logic signed [64:0] round_x;
   logic signed [64:0] round_y;
   logic signed [64:0] round_z;
   rsp_word_type       last_word;
   rsp_word_type       out_ff;
   rsp_word_type       skid_ff;
   logic               out_v_ff;
   logic               skid_v_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_seg_ff <= SEG_W'(16);
         lon_seg_ff <= SEG_W'(32);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LAT_SEGMENTS: lat_seg_ff <= csr_wdata;
            CSR_LON_SEGMENTS: lon_seg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole chain moves unless the output skid slot is occupied.
   assign advance = !skid_v_ff;
   assign req_ready = advance;

   // Clamp the indices and form the four rounded dividends.
   always_comb begin
      lat_eff = eff_seg(lat_seg_ff);
      lon_eff = eff_seg(lon_seg_ff);
      lat_idx = (req_lat_index > lat_eff) ? lat_eff : req_lat_index;
      lon_idx = (req_lon_index > lon_eff) ? lon_eff : req_lon_index;
      clamp_now = (req_lat_index > lat_eff) || (req_lon_index > lon_eff);
      div_src[0].rem = '0;
      div_src[0].nq = (DIV_W'(lat_idx) << THETA_SHIFT) + DIV_W'(lat_eff >> 1);
      div_src[1].rem = '0;
      div_src[1].nq = (DIV_W'(lon_idx) << PHI_SHIFT) + DIV_W'(lon_eff >> 1);
      div_src[2].rem = '0;
      div_src[2].nq = (DIV_W'(lon_idx) << TEX_SHIFT) + DIV_W'(lon_eff >> 1);
      div_src[3].rem = '0;
      div_src[3].nq = (DIV_W'(lat_idx) << TEX_SHIFT) + DIV_W'(lat_eff >> 1);
      lane_seg[0] = lat_eff;
      lane_seg[1] = lon_eff;
      lane_seg[2] = lon_eff;
      lane_seg[3] = lat_eff;
   end

   // Division chains, one cell per dividend bit.
   for (genvar l = 0; l < DIV_LANES; l++) begin : g_div_lane
      for (genvar s = 0; s < DIV_W; s++) begin : g_div_cell
         if (s == 0) begin : g_first
            uvsv_div_cell u_cell (
               .clock     (clock),
               .enable    (advance),
               .divisor   (lane_seg[l]),
               .prev_lane (div_src[l]),
               .next_lane (div_tap[l][s])
            );
         end else begin : g_next
            uvsv_div_cell u_cell (
               .clock     (clock),
               .enable    (advance),
               .divisor   (lane_seg[l]),
               .prev_lane (div_tap[l][s-1]),
               .next_lane (div_tap[l][s])
            );
         end
      end
   end

   // CORDIC inputs from the phase quotients.
   always_comb begin
      th_phase = div_tap[0][DIV_W-1].nq[PHASE_W-1:0];
      ph_phase = div_tap[1][DIV_W-1].nq[PHASE_W-1:0];
      cor_src[0].x = CORDIC_GAIN;
      cor_src[0].y = '0;
      cor_src[0].z = CORDIC_W'(th_phase[PHASE_W-3:0]);
      cor_src[1].x = CORDIC_GAIN;
      cor_src[1].y = '0;
      cor_src[1].z = CORDIC_W'(ph_phase[PHASE_W-3:0]);
   end

   for (genvar l = 0; l < CORDIC_LANES; l++) begin : g_cor_lane
      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cor_cell
         if (s == 0) begin : g_first
            uvsv_cordic_cell #(.STEP(s)) u_cell (
               .clock    (clock),
               .enable   (advance),
               .prev_vec (cor_src[l]),
               .next_vec (cor_tap[l][s])
            );
         end else begin : g_next
            uvsv_cordic_cell #(.STEP(s)) u_cell (
               .clock    (clock),
               .enable   (advance),
               .prev_vec (cor_tap[l][s-1]),
               .next_vec (cor_tap[l][s])
            );
         end
      end
   end

   // Valid bits along the chains.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff <= '0;
         cor_v_ff <= '0;
         map_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
      end else if (advance) begin
         div_v_ff <= {div_v_ff[DIV_W-2:0], req_valid};
         cor_v_ff <= {cor_v_ff[CORDIC_STEPS-2:0], div_v_ff[DIV_W-1]};
         map_v_ff <= cor_v_ff[CORDIC_STEPS-1];
         mul_v_ff <= map_v_ff;
      end
   end

   // Side data traveling with each word, quadrant fold and products.
   always_ff @(posedge clock) begin
      if (advance) begin
         div_clamp_ff <= {div_clamp_ff[DIV_W-2:0], clamp_now};
         cor_clamp_ff <= {cor_clamp_ff[CORDIC_STEPS-2:0], div_clamp_ff[DIV_W-1]};
         cor_tu_ff[0] <= div_tap[2][DIV_W-1].nq[TEX_W-1:0];
         cor_tv_ff[0] <= div_tap[3][DIV_W-1].nq[TEX_W-1:0];
         cor_qt_ff[0] <= quad_type'(th_phase[PHASE_W-1:PHASE_W-2]);
         cor_qp_ff[0] <= quad_type'(ph_phase[PHASE_W-1:PHASE_W-2]);
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            cor_tu_ff[i] <= cor_tu_ff[i-1];
            cor_tv_ff[i] <= cor_tv_ff[i-1];
            cor_qt_ff[i] <= cor_qt_ff[i-1];
            cor_qp_ff[i] <= cor_qp_ff[i-1];
         end
         ct_ff <= quad_cos(cor_qt_ff[CORDIC_STEPS-1], cor_tap[0][CORDIC_STEPS-1]);
         st_ff <= quad_sin(cor_qt_ff[CORDIC_STEPS-1], cor_tap[0][CORDIC_STEPS-1]);
         cp_ff <= quad_cos(cor_qp_ff[CORDIC_STEPS-1], cor_tap[1][CORDIC_STEPS-1]);
         sp_ff <= quad_sin(cor_qp_ff[CORDIC_STEPS-1], cor_tap[1][CORDIC_STEPS-1]);
         map_tu_ff <= cor_tu_ff[CORDIC_STEPS-1];
         map_tv_ff <= cor_tv_ff[CORDIC_STEPS-1];
         map_clamp_ff <= cor_clamp_ff[CORDIC_STEPS-1];
         px_ff <= cp_ff * st_ff;
         pz_ff <= sp_ff * st_ff;
         py_ff <= ct_ff;
         mul_tu_ff <= map_tu_ff;
         mul_tv_ff <= map_tv_ff;
         mul_clamp_ff <= map_clamp_ff;
      end
   end

   // Round to the output fraction and saturate.
   always_comb begin
      round_x = (65'(px_ff) + XZ_BIAS) >>> SHIFT_XZ;
      round_z = (65'(pz_ff) + XZ_BIAS) >>> SHIFT_XZ;
      round_y = (65'(py_ff) + Y_BIAS) >>> SHIFT_Y;
      last_word.pos_x = sat_coord(round_x);
      last_word.pos_y = sat_coord(round_y);
      last_word.pos_z = sat_coord(round_z);
      last_word.tex_u = mul_tu_ff;
      last_word.tex_v = mul_tv_ff;
      last_word.index_clamped = mul_clamp_ff;
   end

   // Output register with one skid slot behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= mul_v_ff;
         end
      end else if (mul_v_ff && advance) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_ff <= skid_v_ff ? skid_ff : last_word;
      end else if (advance) begin
         skid_ff <= last_word;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_pos_x = out_ff.pos_x;
   assign rsp_pos_y = out_ff.pos_y;
   assign rsp_pos_z = out_ff.pos_z;
   assign rsp_tex_u = out_ff.tex_u;
   assign rsp_tex_v = out_ff.tex_v;
   assign rsp_index_clamped = out_ff.index_clamped;

`ifndef ASSERT_OFF
   // The skid slot only fills behind a word already held at the output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid slot holds a word while the output register is empty");

   // A finished word arriving at a stalled output must land in the skid slot.
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (mul_v_ff && !skid_v_ff && out_v_ff && !rsp_ready) |=> skid_v_ff)
      else $error("finished word lost at a stalled output");

   // A taken output drains the skid slot into the output register.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ready) |=> (!skid_v_ff && out_v_ff))
      else $error("skid slot did not drain after the output was taken");
`endif

endmodule

[design/uvsv_div_cell.sv]
module uvsv_div_cell (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [uvsv_pkg::SEG_W-1:0] divisor,
   input  uvsv_pkg::div_lane_type prev_lane,
   output uvsv_pkg::div_lane_type next_lane
);
   import uvsv_pkg::*;

   logic [SEG_W:0] trial;
   logic           take;
   div_lane_type   lane_ff;
   div_lane_type   lane_in;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {prev_lane.rem, prev_lane.nq[DIV_W-1]};
      take = (trial >= {1'b0, divisor});
      lane_in.rem = take ? SEG_W'(trial - {1'b0, divisor}) : SEG_W'(trial);
      lane_in.nq = {prev_lane.nq[DIV_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

[design/uvsv_cordic_cell.sv]
module uvsv_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     enable,
   input  uvsv_pkg::cordic_vec_type prev_vec,
   output uvsv_pkg::cordic_vec_type next_vec
);
   import uvsv_pkg::*;

   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] angle;
   cordic_vec_type             vec_ff;
   cordic_vec_type             vec_in;

   // One micro-rotation toward zero residual angle.
   always_comb begin
      dx = prev_vec.y >>> STEP;
      dy = prev_vec.x >>> STEP;
      angle = atan_turn(STEP_W'(STEP));
      if (!prev_vec.z[CORDIC_W-1]) begin
         vec_in.x = prev_vec.x - dx;
         vec_in.y = prev_vec.y + dy;
         vec_in.z = prev_vec.z - angle;
      end else begin
         vec_in.x = prev_vec.x + dx;
         vec_in.y = prev_vec.y - dy;
         vec_in.z = prev_vec.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign next_vec = vec_ff;

endmodule
